// ----- sv/mtp_pkg.sv -----
package mtp_pkg;

  // Largest number of timers the event and interrupt status bits can hold.
  localparam int MAX_TIMERS     = 8;
  localparam int NUM_TIMERS_DEF = 8;

  // Item kinds. The fourth code is a no-op.
  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_TICK  = 2'd2
  } req_type_t;

  // Global register byte offsets.
  localparam logic [11:0] OFF_MASTER   = 12'h000;
  localparam logic [11:0] OFF_CONFIG   = 12'h008;
  localparam logic [11:0] OFF_GCOUNT   = 12'h00C;
  localparam logic [11:0] OFF_IRQ_STAT = 12'h010;
  localparam logic [11:0] OFF_IRQ_MASK = 12'h014;
  localparam logic [11:0] OFF_IRQ_CLR  = 12'h018;

  // Register offsets inside one timer block.
  localparam logic [4:0] TREG_COUNT = 5'h00;
  localparam logic [4:0] TREG_LOAD  = 5'h04;
  localparam logic [4:0] TREG_MATCH = 5'h08;
  localparam logic [4:0] TREG_CTRL  = 5'h0C;
  localparam logic [4:0] TREG_PRESC = 5'h10;

  // Timer control bit positions.
  localparam int CTL_ENABLE  = 0;
  localparam int CTL_ONESHOT = 1;
  localparam int CTL_IRQ     = 2;
  localparam int CTL_MATCH   = 4;
  localparam int CTL_LOADEN  = 5;
  localparam int CTL_RESET   = 6;
  localparam int CTL_WRAP    = 7;

  localparam logic [31:0] MASTER_RESET   = 32'h0000_0001;
  localparam logic [31:0] IRQ_MASK_RESET = 32'hFFFF_FFFF;

  // One result word.
  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_line;
    logic [7:0]  timer_events;
  } rsp_t;

  // Load value of a timer after reset.
  function automatic logic [31:0] load_reset(input int idx);
    logic [31:0] val;
    case (idx)
      0: val = 32'hFFFF_FFFF;
      1: val = 32'd16666666;
      2: val = 32'd20833;
      default: val = 32'd0;
    endcase
    return val;
  endfunction

  // Control value of a timer after reset.
  function automatic logic [31:0] control_reset(input int idx);
    logic [31:0] val;
    case (idx)
      0: val = 32'h0000_0081;
      1: val = 32'h0000_0005;
      2: val = 32'h0000_0005;
      default: val = 32'd0;
    endcase
    return val;
  endfunction

endpackage

// ----- sv/mtp_if.sv -----
// Request channel: one bus access or tick per word.
interface mtp_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [11:0] bus_offset;
  logic [31:0] write_data;
  logic [7:0]  tick_mask;

  modport source (output valid, req_type, bus_offset, write_data, tick_mask, input ready);
  modport sink (input valid, req_type, bus_offset, write_data, tick_mask, output ready);
endinterface

// Response channel: one result word per request.
interface mtp_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        irq_line;
  logic [7:0]  timer_events;

  modport source (output valid, read_data, irq_line, timer_events, input ready);
  modport sink (input valid, read_data, irq_line, timer_events, output ready);
endinterface

// ----- sv/multi_timer_peripheral.sv -----
// Multi-channel timer peripheral. Every request word is a bus read, a bus write or a
// reference tick, and produces exactly one response word. A request is accepted in any
// cycle in which fewer than two responses are waiting; its response is queued in the
// same cycle. All register updates and any timer tick steps happen in the single
// cycle of acceptance, so the sustained rate is one word per clock, set only by the
// two-entry response queue when the response side stalls. The timers each have a
// prescaler, a down-with-reload or up-with-wrap mode, a match compare and a oneshot
// disarm; interrupt status collects their events and drives the irq line.
module multi_timer_peripheral #(
  parameter int NUM_TIMERS = mtp_pkg::NUM_TIMERS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  mtp_req_if.sink   req,
  mtp_rsp_if.source rsp
);

  // Timer state.
  logic [31:0] tmr_count [NUM_TIMERS];
  logic [31:0] timer_load [NUM_TIMERS];
  logic [31:0] timer_match [NUM_TIMERS];
  logic [31:0] timer_control [NUM_TIMERS];
  logic [7:0]  timer_prescale [NUM_TIMERS];
  logic [7:0]  prescale_progress [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] timer_armed;

  logic [31:0] tmr_count_next [NUM_TIMERS];
  logic [31:0] timer_load_next [NUM_TIMERS];
  logic [31:0] timer_match_next [NUM_TIMERS];
  logic [31:0] timer_control_next [NUM_TIMERS];
  logic [7:0]  timer_prescale_next [NUM_TIMERS];
  logic [7:0]  prescale_progress_next [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] timer_armed_next;

  // Global state.
  logic [31:0] master_control, master_control_next;
  logic [31:0] config_word, config_word_next;
  logic [63:0] global_ticks, global_ticks_next;
  logic [7:0]  irq_pending, irq_pending_next;
  logic [31:0] irq_enable_mask, irq_enable_mask_next;
  logic        irq_level, irq_level_next;

  // Per-timer tick step results.
  logic [31:0] step_count [NUM_TIMERS];
  logic [7:0]  step_progress [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] step_hold;
  logic [NUM_TIMERS-1:0] step_clear;
  logic [NUM_TIMERS-1:0] step_pulse;
  logic [NUM_TIMERS-1:0] blk_hit;

  logic [mtp_pkg::MAX_TIMERS-1:0] events;
  logic [31:0] read_value;
  logic        accept;
  logic [6:0]  blk_sel;
  logic [4:0]  treg;

  // Response queue.
  mtp_pkg::rsp_t rsp_new;
  mtp_pkg::rsp_t slot0, slot1;
  logic [1:0]    fill;
  logic          push, pop;

  assign accept    = req.valid && req.ready;
  assign req.ready = (fill != 2'd2);
  assign blk_sel   = req.bus_offset[11:5];
  assign treg      = req.bus_offset[4:0];

  // Tick step of each timer, computed from its current state.
  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_tmr
    logic [8:0]  pinc;
    logic        presc_on;
    logic        wrap;
    logic        ovf;
    logic [31:0] cnt;

    assign blk_hit[i] = (blk_sel == 7'(i + 1));
    assign pinc       = {1'b0, prescale_progress[i]} + 9'd1;
    assign presc_on   = (timer_prescale[i] != 8'd0);
    assign step_hold[i]     = presc_on && (pinc < {1'b0, timer_prescale[i]});
    assign step_clear[i]    = presc_on;
    assign step_progress[i] = pinc[7:0];
    assign wrap = timer_control[i][mtp_pkg::CTL_WRAP];
    assign ovf  = wrap ? (tmr_count[i] == 32'd0) : (tmr_count[i] == 32'hFFFF_FFFF);

    always_comb begin
      if (wrap) begin
        cnt = ovf ? timer_load[i] : tmr_count[i] - 32'd1;
      end else if (ovf) begin
        cnt = timer_control[i][mtp_pkg::CTL_LOADEN] ? timer_load[i] : 32'd0;
      end else begin
        cnt = tmr_count[i] + 32'd1;
      end
    end

    assign step_count[i] = cnt;
    assign step_pulse[i] = timer_control[i][mtp_pkg::CTL_IRQ] &&
                           (ovf || (timer_control[i][mtp_pkg::CTL_MATCH] &&
                                    cnt == timer_match[i]));
  end

  // Next state and result of the accepted word.
  always_comb begin
    master_control_next  = master_control;
    config_word_next     = config_word;
    global_ticks_next    = global_ticks;
    irq_pending_next     = irq_pending;
    irq_enable_mask_next = irq_enable_mask;
    irq_level_next       = irq_level;
    timer_armed_next     = timer_armed;
    events               = '0;
    read_value           = 32'd0;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      tmr_count_next[i]         = tmr_count[i];
      timer_load_next[i]        = timer_load[i];
      timer_match_next[i]       = timer_match[i];
      timer_control_next[i]     = timer_control[i];
      timer_prescale_next[i]    = timer_prescale[i];
      prescale_progress_next[i] = prescale_progress[i];
    end

    if (accept) begin
      case (req.req_type)
        mtp_pkg::REQ_READ: begin
          case (req.bus_offset)
            mtp_pkg::OFF_MASTER:   read_value = master_control;
            mtp_pkg::OFF_CONFIG:   read_value = config_word;
            mtp_pkg::OFF_GCOUNT:   read_value = global_ticks[31:0];
            mtp_pkg::OFF_IRQ_STAT: read_value = {24'd0, irq_pending};
            mtp_pkg::OFF_IRQ_MASK: read_value = irq_enable_mask;
            default: begin
              // At most one timer block matches; OR the selected register in.
              for (int i = 0; i < NUM_TIMERS; i++) begin
                if (blk_hit[i]) begin
                  case (treg)
                    mtp_pkg::TREG_COUNT: read_value = read_value | tmr_count[i];
                    mtp_pkg::TREG_LOAD:  read_value = read_value | timer_load[i];
                    mtp_pkg::TREG_MATCH: read_value = read_value | timer_match[i];
                    mtp_pkg::TREG_CTRL:  read_value = read_value | timer_control[i];
                    mtp_pkg::TREG_PRESC: read_value = read_value | {24'd0, timer_prescale[i]};
                    default: ;
                  endcase
                end
              end
            end
          endcase
        end

        mtp_pkg::REQ_WRITE: begin
          case (req.bus_offset)
            mtp_pkg::OFF_MASTER:   master_control_next = req.write_data;
            mtp_pkg::OFF_CONFIG:   config_word_next = req.write_data;
            mtp_pkg::OFF_GCOUNT:   global_ticks_next = {32'd0, req.write_data};
            mtp_pkg::OFF_IRQ_MASK: irq_enable_mask_next = req.write_data;
            mtp_pkg::OFF_IRQ_CLR: begin
              irq_pending_next = irq_pending & ~req.write_data[7:0];
              if ((irq_pending_next & irq_enable_mask[7:0]) == 8'd0) begin
                irq_level_next = 1'b0;
              end
            end
            default: begin
              for (int i = 0; i < NUM_TIMERS; i++) begin
                if (blk_hit[i]) begin
                  case (treg)
                    mtp_pkg::TREG_COUNT: tmr_count_next[i] = req.write_data;
                    mtp_pkg::TREG_LOAD: begin
                      timer_load_next[i] = req.write_data;
                      if (timer_control[i][mtp_pkg::CTL_LOADEN]) begin
                        tmr_count_next[i] = req.write_data;
                      end
                    end
                    mtp_pkg::TREG_MATCH: timer_match_next[i] = req.write_data;
                    mtp_pkg::TREG_CTRL: begin
                      timer_control_next[i] = req.write_data;
                      timer_armed_next[i]   = req.write_data[mtp_pkg::CTL_ENABLE];
                      if (req.write_data[mtp_pkg::CTL_RESET]) begin
                        tmr_count_next[i]         = timer_load[i];
                        prescale_progress_next[i] = 8'd0;
                      end
                    end
                    mtp_pkg::TREG_PRESC: timer_prescale_next[i] = req.write_data[7:0];
                    default: ;
                  endcase
                end
              end
            end
          endcase
        end

        mtp_pkg::REQ_TICK: begin
          global_ticks_next = global_ticks + 64'd1;
          if (master_control[0]) begin
            for (int i = 0; i < NUM_TIMERS; i++) begin
              if (req.tick_mask[i] && timer_armed[i]) begin
                if (step_hold[i]) begin
                  prescale_progress_next[i] = step_progress[i];
                end else begin
                  if (step_clear[i]) begin
                    prescale_progress_next[i] = 8'd0;
                  end
                  tmr_count_next[i] = step_count[i];
                  events[i]         = step_pulse[i];
                  if (timer_control[i][mtp_pkg::CTL_ONESHOT]) begin
                    timer_armed_next[i] = 1'b0;
                  end
                end
              end
            end
          end
          if (events != '0) begin
            irq_pending_next = irq_pending | events;
            if ((irq_pending_next & irq_enable_mask[7:0]) != 8'd0) begin
              irq_level_next = 1'b1;
            end
          end
        end

        default: ;
      endcase
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
        tmr_count[i]         <= mtp_pkg::load_reset(i);
        timer_load[i]        <= mtp_pkg::load_reset(i);
        timer_match[i]       <= 32'd0;
        timer_control[i]     <= mtp_pkg::control_reset(i);
        timer_prescale[i]    <= 8'd0;
        prescale_progress[i] <= 8'd0;
      end
      timer_armed     <= '0;
      master_control  <= mtp_pkg::MASTER_RESET;
      config_word     <= 32'd0;
      global_ticks    <= 64'd0;
      irq_pending     <= 8'd0;
      irq_enable_mask <= mtp_pkg::IRQ_MASK_RESET;
      irq_level       <= 1'b0;
    end else begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
        tmr_count[i]         <= tmr_count_next[i];
        timer_load[i]        <= timer_load_next[i];
        timer_match[i]       <= timer_match_next[i];
        timer_control[i]     <= timer_control_next[i];
        timer_prescale[i]    <= timer_prescale_next[i];
        prescale_progress[i] <= prescale_progress_next[i];
      end
      timer_armed     <= timer_armed_next;
      master_control  <= master_control_next;
      config_word     <= config_word_next;
      global_ticks    <= global_ticks_next;
      irq_pending     <= irq_pending_next;
      irq_enable_mask <= irq_enable_mask_next;
      irq_level       <= irq_level_next;
    end
  end

  // Two-entry response queue; slot0 is the head.
  assign rsp_new.read_data    = read_value;
  assign rsp_new.irq_line     = irq_level_next;
  assign rsp_new.timer_events = events;
  assign push = accept;
  assign pop  = rsp.valid && rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 2'd0;
    end else if (push && !pop) begin
      fill <= fill + 2'd1;
    end else if (pop && !push) begin
      fill <= fill - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push && pop) begin
      if (fill == 2'd1) begin
        slot0 <= rsp_new;
      end else begin
        slot0 <= slot1;
        slot1 <= rsp_new;
      end
    end else if (push) begin
      if (fill == 2'd0) begin
        slot0 <= rsp_new;
      end else begin
        slot1 <= rsp_new;
      end
    end else if (pop) begin
      slot0 <= slot1;
    end
  end

  assign rsp.valid        = (fill != 2'd0);
  assign rsp.read_data    = slot0.read_data;
  assign rsp.irq_line     = slot0.irq_line;
  assign rsp.timer_events = slot0.timer_events;

endmodule

// ----- sv/mtp_checker.sv -----
module mtp_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic [1:0]  req_type,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [31:0] rsp_read_data,
  input logic        rsp_irq_line,
  input logic [7:0]  rsp_timer_events
);

  logic req_fire;

  assign req_fire = req_valid && req_ready;

  // Every accepted word leaves a response pending in the next cycle.
  a_rsp_follows: assert property (@(posedge clk) disable iff (rst)
    req_fire |=> rsp_valid)
    else $error("accepted request left no response");

  // With no response waiting, the block must take requests.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid |-> req_ready)
    else $error("request side stalled with an empty response queue");

  // A stalled response holds its word.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=>
      (rsp_valid && $stable(rsp_read_data) && $stable(rsp_irq_line) &&
       $stable(rsp_timer_events)))
    else $error("stalled response changed");

  // A word other than a read returns zero read data.
  a_nonread_zero: assert property (@(posedge clk) disable iff (rst)
    (req_fire && !rsp_valid && req_type != mtp_pkg::REQ_READ) |=>
      (rsp_read_data == 32'd0))
    else $error("read data on a response to a non-read");

  // Only ticks raise timer events.
  a_events_on_tick: assert property (@(posedge clk) disable iff (rst)
    (req_fire && !rsp_valid && req_type != mtp_pkg::REQ_TICK) |=>
      (rsp_timer_events == 8'd0))
    else $error("timer events on a response to a non-tick");

endmodule

bind multi_timer_peripheral mtp_checker u_mtp_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .req_type         (req.req_type),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_read_data    (rsp.read_data),
  .rsp_irq_line     (rsp.irq_line),
  .rsp_timer_events (rsp.timer_events)
);
